[src/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants of the rolling block checksum.
// ----------------------------------------------------------------------------
`default_nettype none
package rbc_pkg;

	localparam logic [16:0] PRIME       = 17'd65521;
	localparam logic [15:0] PRIME_M1    = 16'd65520;
	localparam logic [3:0]  FOLD_MULT   = 4'd15;
	localparam int          FOLDS       = 3;
	localparam int          ACC_W       = 49;

	localparam logic [1:0] REG_USE_POLY = 2'd0;
	localparam logic [1:0] REG_MULT1    = 2'd1;
	localparam logic [1:0] REG_MULT2    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ABS_WAIT,
		ST_EXTEND,
		ST_EXT_WAIT,
		ST_READ,
		ST_ROLL_MUL,
		ST_ROLL_WAIT,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

[src/rolling_block_checksum.sv]
// ----------------------------------------------------------------------------
// rolling_block_checksum
// Weak 32-bit block checksum with Adler-style and dual polynomial modes.
// ----------------------------------------------------------------------------
// The input channel carries one beat per byte to absorb or per window roll.
// Absorbed bytes update the running sums; the last byte of a block gives one
// result beat and clears the sums. Every roll gives one result beat. The user
// must write configuration over the APB port only while the block is idle; the
// block does not enforce it. A write of either multiplier empties the power table.
// One item is in work at a time. Polynomial absorbs and rolls shorter than
// MAX_WINDOW go through the two mod-65521 units, which load a * b + c, apply
// FOLDS folds and reduce the result; a roll to a window longer than any seen
// since the table was emptied first extends the table, one entry per pass of
// the mod units.
// A new beat is taken only in the idle state, after the previous item is done.
// Reset clears the sums, the table fill count and out_valid, and sets the
// configuration to its defaults; the table memory itself needs no clearing pass.
// A finished result waits in the output register while the receiver stalls;
// the next item is then accepted but held before its result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module rolling_block_checksum
	import rbc_pkg::*;
#(
	parameter int MAX_WINDOW  = 4096,
	parameter int BYTE_OFFSET = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  old_byte,
	input  wire logic [11:0] window_len,
	input  wire logic        more,
	input  wire logic        last,
	input  wire logic [31:0] sum_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] checksum,
	output logic             window_error
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int RW = $clog2(MAX_WINDOW + 1);

	state_t state_q, state_d;

	logic        use_poly_q;
	logic [15:0] mult1_q, mult2_q;
	logic [31:0] sum_low_q, sum_high_q;
	logic [RW-1:0] ready_q;
	logic [31:0] prev_q;

	logic        func_q, more_q, last_q;
	logic [7:0]  data_q, old_q;
	logic [11:0] k_q;
	logic [31:0] sum_in_q;
	logic [24:0] c1_q, c2_q;
	logic [31:0] res_q;
	logic        res_err_q;

	logic        out_valid_q;
	logic [31:0] checksum_q;
	logic        window_error_q;

	logic        cfg_wr;
	logic [31:0] k32, ready32;
	logic        too_long, have_entry;

	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0] mem_wdata, mem_rdata;

	logic        mm_start;
	logic [31:0] mm1_a, mm2_a;
	logic [15:0] mm1_b, mm2_b;
	logic [24:0] mm1_c, mm2_c;
	logic        mm1_done, mm2_done, mm_done;
	logic [15:0] mm1_res, mm2_res;

	logic [31:0] sb_data, sb_old;
	logic [31:0] a_low, a_high;
	logic [31:0] r1_base, r2_base, r1, r2;
	logic        out_free;

	assign sb_data = {{24{data_q[7]}}, data_q} + 32'(BYTE_OFFSET);
	assign sb_old  = {{24{old_q[7]}}, old_q} + 32'(BYTE_OFFSET);
	assign a_low   = sum_low_q + sb_data;
	assign a_high  = sum_high_q + a_low;
	assign r1_base = {16'd0, sum_in_q[15:0]} - sb_old;
	assign r2_base = {16'd0, sum_in_q[31:16]} - 32'({20'd0, k_q} * sb_old);
	assign r1      = more_q ? r1_base + sb_data : r1_base;
	assign r2      = more_q ? r2_base + r1 : r2_base;

	assign k32        = {20'd0, k_q};
	assign ready32    = 32'(ready_q);
	assign too_long   = k32 >= 32'(MAX_WINDOW);
	assign have_entry = ready32 > k32;
	assign out_free   = !out_valid_q || !out_stall;
	assign mm_done    = mm1_done && mm2_done;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			REG_USE_POLY: prdata = {31'd0, use_poly_q};
			REG_MULT1:    prdata = {16'd0, mult1_q};
			REG_MULT2:    prdata = {16'd0, mult2_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!use_poly_q) begin
					state_d = (func_q || last_q) ? ST_EMIT : ST_IDLE;
				end else if (!func_q) begin
					state_d = ST_ABS_WAIT;
				end else if (too_long) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_EXTEND;
				end
			end
			ST_ABS_WAIT: begin
				if (mm_done) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EXTEND: begin
				state_d = have_entry ? ST_READ : ST_EXT_WAIT;
			end
			ST_EXT_WAIT: begin
				if (mm_done) begin
					state_d = ST_EXTEND;
				end
			end
			ST_READ:      state_d = ST_ROLL_MUL;
			ST_ROLL_MUL:  state_d = ST_ROLL_WAIT;
			ST_ROLL_WAIT: begin
				if (mm_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ready_q[AW-1:0];
		mem_wdata = {mm2_res, mm1_res};
		mem_raddr = k32[AW-1:0];
		mm_start  = 1'b0;
		mm1_a     = prev_q & 32'h0000ffff;
		mm2_a     = {16'd0, prev_q[31:16]};
		mm1_b     = mult1_q;
		mm2_b     = mult2_q;
		mm1_c     = '0;
		mm2_c     = '0;
		unique case (state_q)
			ST_DECODE: begin
				mm1_a = sum_low_q;
				mm2_a = sum_high_q;
				mm1_c = {17'd0, data_q};
				mm2_c = {17'd0, data_q};
				if (use_poly_q && !func_q) begin
					mm_start = 1'b1;
				end
				if (use_poly_q && func_q && !too_long && ready_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = {PRIME_M1, PRIME_M1};
				end
			end
			ST_EXTEND: begin
				if (!have_entry) begin
					mm_start = 1'b1;
				end
			end
			ST_EXT_WAIT: begin
				mem_we = mm_done;
			end
			ST_ROLL_MUL: begin
				mm1_a    = {16'd0, sum_in_q[15:0]};
				mm2_a    = {16'd0, sum_in_q[31:16]};
				mm1_c    = c1_q;
				mm2_c    = c2_q;
				mm_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			use_poly_q  <= 1'b0;
			mult1_q     <= 16'd1;
			mult2_q     <= 16'd1;
			sum_low_q   <= '0;
			sum_high_q  <= '0;
			ready_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_USE_POLY: use_poly_q <= pwdata[0];
					REG_MULT1: begin
						mult1_q <= pwdata[15:0];
						ready_q <= '0;
					end
					REG_MULT2: begin
						mult2_q <= pwdata[15:0];
						ready_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_DECODE: begin
					if (!use_poly_q && !func_q) begin
						sum_low_q  <= last_q ? 32'd0 : a_low;
						sum_high_q <= last_q ? 32'd0 : a_high;
					end
					if (mem_we) begin
						ready_q <= RW'(1);
					end
				end
				ST_ABS_WAIT: begin
					if (mm_done) begin
						sum_low_q  <= last_q ? 32'd0 : {16'd0, mm1_res};
						sum_high_q <= last_q ? 32'd0 : {16'd0, mm2_res};
					end
				end
				ST_EXT_WAIT: begin
					if (mm_done) begin
						ready_q <= ready_q + RW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q   <= func;
			data_q   <= data_byte;
			old_q    <= old_byte;
			k_q      <= window_len;
			more_q   <= more;
			last_q   <= last;
			sum_in_q <= sum_in;
		end
		unique case (state_q)
			ST_DECODE: begin
				res_err_q <= 1'b0;
				if (mem_we) begin
					prev_q <= {PRIME_M1, PRIME_M1};
				end
				if (!use_poly_q) begin
					res_q <= func_q ? {r2[15:0], r1[15:0]} : {a_high[15:0], a_low[15:0]};
				end else if (func_q && too_long) begin
					res_q     <= '0;
					res_err_q <= 1'b1;
				end
			end
			ST_ABS_WAIT, ST_ROLL_WAIT: begin
				if (mm_done) begin
					res_q <= {mm2_res, mm1_res};
				end
			end
			ST_EXT_WAIT: begin
				if (mm_done) begin
					prev_q <= {mm2_res, mm1_res};
				end
			end
			ST_READ: begin
				c1_q <= 25'(mem_rdata[15:0] * old_q) + (more_q ? {17'd0, data_q} : 25'd0);
				c2_q <= 25'(mem_rdata[31:16] * old_q) + (more_q ? {17'd0, data_q} : 25'd0);
			end
			ST_EMIT: begin
				if (out_free) begin
					checksum_q     <= res_q;
					window_error_q <= res_err_q;
				end
			end
			default: begin
			end
		endcase
	end

	rbc_ram #(
		.WIDTH(32),
		.DEPTH(MAX_WINDOW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rbc_mulmod u_mm1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm1_a),
		.b      (mm1_b),
		.c      (mm1_c),
		.done   (mm1_done),
		.result (mm1_res)
	);

	rbc_mulmod u_mm2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm2_a),
		.b      (mm2_b),
		.c      (mm2_c),
		.done   (mm2_done),
		.result (mm2_res)
	);

	assign in_stall     = state_q != ST_IDLE;
	assign out_valid    = out_valid_q;
	assign checksum     = checksum_q;
	assign window_error = window_error_q;

endmodule
`default_nettype wire

[src/rbc_ram.sv]
// ----------------------------------------------------------------------------
// rbc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[src/rbc_mulmod.sv]
// ----------------------------------------------------------------------------
// rbc_mulmod
// Multi-cycle (a * b + c) mod 65521 using folds of 2^16 = 15 (mod 65521).
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_mulmod
	import rbc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [15:0] b,
	input  wire logic [24:0] c,
	output logic             done,
	output logic [15:0]      result
);

	logic [ACC_W-1:0] acc_q;
	logic [1:0]       cnt_q;
	logic             busy_q;
	logic [16:0]      low17;
	logic [16:0]      diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 2'(FOLDS)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= ACC_W'(a * b) + ACC_W'(c);
		end else if (busy_q && cnt_q != 2'(FOLDS)) begin
			acc_q <= ACC_W'(acc_q[ACC_W-1:16] * FOLD_MULT) + ACC_W'(acc_q[15:0]);
		end
	end

	assign low17  = acc_q[16:0];
	assign diff   = low17 - PRIME;
	assign done   = busy_q && cnt_q == 2'(FOLDS);
	assign result = (low17 >= PRIME) ? diff[15:0] : low17[15:0];

endmodule
`default_nettype wire
